// File: hw/rtl/dual_time_proportional_heater_drive_top_macros.svh
// Assertion macros shared by the heater drive RTL.
`ifndef DUAL_TIME_PROPORTIONAL_HEATER_DRIVE_TOP_MACROS_SVH
`define DUAL_TIME_PROPORTIONAL_HEATER_DRIVE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTPHD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTPHD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/dtphd_pkg.sv
// Shared widths, register indexes and constants of the heater drive.
`timescale 1ns / 1ps
package dtphd_pkg;

	localparam int RAW_W = 13;
	localparam int DEMAND_W = 12;
	localparam int TEMP_W = 14;
	localparam int CNT_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int BREW_TGT_W = 11;
	localparam int STEAM_TGT_W = 12;
	localparam int OFFSET_W = 9;
	localparam int DIFF_W = 16;

	// Width of the quotient of a rounded-up demand by the mains period
	localparam int QUOT_W = 13;

	localparam int MAINS_FREQUENCY_HZ_DEF = 60;
	localparam int PERIOD_MS_DEF = 1000 / MAINS_FREQUENCY_HZ_DEF;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Bang-bang band on set point minus temperature: +5 degC and -1 degC in 1/16 degC
	localparam logic signed [DIFF_W-1:0] OVER_BAND = 16'sd80;
	localparam logic signed [DIFF_W-1:0] UNDER_BAND = -16'sd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BREW_TARGET = 3'd0,
		REG_STEAM_TARGET = 3'd1,
		REG_PROBE_OFFSET = 3'd2,
		REG_WINDOW_LENGTH = 3'd3,
		REG_SAMPLE_INTERVAL = 3'd4,
		REG_SHUTOFF_TEMP = 3'd5
	} cfg_reg_t;

	localparam logic [BREW_TGT_W-1:0] BREW_TARGET_RST = 11'd1472;
	localparam logic [STEAM_TGT_W-1:0] STEAM_TARGET_RST = 12'd2240;
	localparam logic signed [OFFSET_W-1:0] PROBE_OFFSET_RST = -9'sd128;
	localparam logic [CNT_W-1:0] WINDOW_LENGTH_RST = 12'd1500;
	localparam logic [CNT_W-1:0] SAMPLE_INTERVAL_RST = 12'd500;
	localparam logic [CNT_W-1:0] SHUTOFF_TEMP_RST = 12'd2640;

endpackage

// File: hw/rtl/dtphd_if.sv
// Valid/ready channel interfaces for ticks, relay results and register writes.
`timescale 1ns / 1ps
interface dtphd_tick_if;
	import dtphd_pkg::*;
	logic valid;
	logic ready;
	logic signed [RAW_W-1:0] raw_temp;
	logic [DEMAND_W-1:0] brew_demand;
	logic [DEMAND_W-1:0] steam_demand;
	modport source (output valid, raw_temp, brew_demand, steam_demand, input ready);
	modport sink (input valid, raw_temp, brew_demand, steam_demand, output ready);
endinterface

interface dtphd_drive_if;
	import dtphd_pkg::*;
	logic valid;
	logic ready;
	logic heater_on;
	logic steam_on;
	logic shutoff;
	logic sample_strobe;
	logic signed [TEMP_W-1:0] held_temp;
	modport source (output valid, heater_on, steam_on, shutoff, sample_strobe, held_temp,
		input ready);
	modport sink (input valid, heater_on, steam_on, shutoff, sample_strobe, held_temp,
		output ready);
endinterface

interface dtphd_cfg_if;
	import dtphd_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

// File: hw/rtl/dtphd_quot.sv
// Ceiling division of a demand by the mains period through a reciprocal multiply.
`timescale 1ns / 1ps
module dtphd_quot #(
	parameter int PERIOD_MS = dtphd_pkg::PERIOD_MS_DEF
) (
	input  logic [dtphd_pkg::DEMAND_W-1:0] demand,
	output logic [dtphd_pkg::QUOT_W-1:0]   quot
);
	import dtphd_pkg::*;

	// Biased demand stays below 2**XW; 2**K >= 2**XW * PERIOD_MS keeps the
	// reciprocal exact over that whole range.
	localparam int XW = DEMAND_W + 1;
	localparam int K = XW + $clog2(PERIOD_MS + 1);
	localparam int RECIP = (2 ** K + PERIOD_MS - 1) / PERIOD_MS;
	localparam int MW = $clog2(RECIP + 1);

	logic [XW-1:0]    biased;
	logic [XW+MW-1:0] prod;

	assign biased = {1'b0, demand} + XW'(PERIOD_MS - 1);
	assign prod = {{MW{1'b0}}, biased} * {{XW{1'b0}}, MW'(RECIP)};
	assign quot = QUOT_W'(prod >> K);

endmodule

// File: hw/rtl/dual_time_proportional_heater_drive_top.sv
// Top level of the dual time-proportional heater relay drive.
`timescale 1ns / 1ps
`include "dual_time_proportional_heater_drive_top_macros.svh"
// Each tick request is one millisecond of a brew/steam heater controller:
// raw probe temperature plus two on-time demands. Every tick gives exactly
// one drive result (two relay bits, shutoff flag, sample strobe and the held
// corrected temperature). One tick is accepted per clock while the drive
// side does not stall; its result passes the input register, the demand
// quotient stage and the result register. The window and sample counters,
// which the next tick needs, update as each tick enters the result register.
// A held result does not block the input side until both internal stages
// are full. Registers are to be written through cfg (index 0..5: brew
// target, steam target, probe offset, window length, sample interval,
// shutoff temperature) only while no tick is in flight; the block does
// not enforce this. Writes to other indexes are dropped. A raw reading
// that is negative or at/above the shutoff temperature turns both relays
// off and latches nothing; the elapsed counters count on and saturate at 4095.
module dual_time_proportional_heater_drive_top #(
	parameter int MAINS_FREQUENCY_HZ = dtphd_pkg::MAINS_FREQUENCY_HZ_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dtphd_cfg_if.sink   cfg,
	dtphd_tick_if.sink  tick,
	dtphd_drive_if.source drive
);
	import dtphd_pkg::*;

	// Mains period in ms, never below one
	localparam int PERIOD_MS = (1000 / MAINS_FREQUENCY_HZ > 0) ?
		(1000 / MAINS_FREQUENCY_HZ) : 1;
	localparam int PW = $clog2(PERIOD_MS + 1);
	localparam int RW = QUOT_W + PW;

	// ---------------------------------------------------------------
	// Configuration registers: always ready, write on handshake
	// ---------------------------------------------------------------
	logic [BREW_TGT_W-1:0]      brew_tgt_q;
	logic [STEAM_TGT_W-1:0]     steam_tgt_q;
	logic signed [OFFSET_W-1:0] offset_q;
	logic [CNT_W-1:0]           window_len_q;
	logic [CNT_W-1:0]           interval_q;
	logic [CNT_W-1:0]           shutoff_tmp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brew_tgt_q    <= BREW_TARGET_RST;
			steam_tgt_q   <= STEAM_TARGET_RST;
			offset_q      <= PROBE_OFFSET_RST;
			window_len_q  <= WINDOW_LENGTH_RST;
			interval_q    <= SAMPLE_INTERVAL_RST;
			shutoff_tmp_q <= SHUTOFF_TEMP_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.idx))
				REG_BREW_TARGET:     brew_tgt_q    <= cfg.data[BREW_TGT_W-1:0];
				REG_STEAM_TARGET:    steam_tgt_q   <= cfg.data[STEAM_TGT_W-1:0];
				REG_PROBE_OFFSET:    offset_q      <= $signed(cfg.data[OFFSET_W-1:0]);
				REG_WINDOW_LENGTH:   window_len_q  <= cfg.data;
				REG_SAMPLE_INTERVAL: interval_q    <= cfg.data;
				REG_SHUTOFF_TEMP:    shutoff_tmp_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: each stage advances when the one after it is free
	// ---------------------------------------------------------------
	logic out_valid_q;
	logic v_s1;
	logic v_s2;
	logic out_free;
	logic en2;
	logic en1;

	assign out_free = !out_valid_q || drive.ready;
	assign en2 = !v_s2 || out_free;
	assign en1 = !v_s1 || en2;
	assign tick.ready = en1;

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic signed [RAW_W-1:0] raw_s1;
	logic [DEMAND_W-1:0]     brew_dem_s1;
	logic [DEMAND_W-1:0]     steam_dem_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && tick.valid) begin
			raw_s1       <= tick.raw_temp;
			brew_dem_s1  <= tick.brew_demand;
			steam_dem_s1 <= tick.steam_demand;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: demand quotients by the mains period (state free)
	// ---------------------------------------------------------------
	logic [QUOT_W-1:0]       brew_quot;
	logic [QUOT_W-1:0]       steam_quot;
	logic [QUOT_W-1:0]       brew_quot_s2;
	logic [QUOT_W-1:0]       steam_quot_s2;
	logic signed [RAW_W-1:0] raw_s2;

	dtphd_quot #(.PERIOD_MS(PERIOD_MS)) u_brew_quot (
		.demand (brew_dem_s1),
		.quot   (brew_quot)
	);

	dtphd_quot #(.PERIOD_MS(PERIOD_MS)) u_steam_quot (
		.demand (steam_dem_s1),
		.quot   (steam_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			raw_s2        <= raw_s1;
			brew_quot_s2  <= brew_quot;
			steam_quot_s2 <= steam_quot;
		end
	end

	// ---------------------------------------------------------------
	// Tick update: counters, sample latch, window latch, relay compare
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]         win_el_q;
	logic [CNT_W-1:0]         samp_el_q;
	logic signed [TEMP_W-1:0] corr_q;
	logic [CNT_W-1:0]         brew_on_q;
	logic [CNT_W-1:0]         steam_on_q;

	logic                     step;
	logic [CNT_W-1:0]         win_inc;
	logic [CNT_W-1:0]         samp_inc;
	logic                     shut;
	logic                     samp_evt;
	logic                     win_evt;
	logic [CNT_W-1:0]         win_next;
	logic [CNT_W-1:0]         samp_next;
	logic signed [TEMP_W-1:0] corr_next;
	logic [RW-1:0]            brew_round_w;
	logic [RW-1:0]            steam_round_w;
	logic [CNT_W-1:0]         brew_round;
	logic [CNT_W-1:0]         steam_round;
	logic signed [DIFF_W-1:0] brew_diff;
	logic signed [DIFF_W-1:0] steam_diff;
	logic signed [DIFF_W-1:0] corr_ext;
	logic [CNT_W-1:0]         brew_on_new;
	logic [CNT_W-1:0]         steam_on_new;
	logic [CNT_W-1:0]         brew_on_next;
	logic [CNT_W-1:0]         steam_on_next;
	logic                     heater_next;
	logic                     steam_next;

	assign step = v_s2 && out_free;

	// Advance both elapsed counters, holding at full scale
	assign win_inc  = (win_el_q == CNT_MAX) ? win_el_q : win_el_q + 1'b1;
	assign samp_inc = (samp_el_q == CNT_MAX) ? samp_el_q : samp_el_q + 1'b1;

	// Negative reading or at/above the limit forces the relays off
	assign shut = raw_s2[RAW_W-1] || (raw_s2[CNT_W-1:0] >= shutoff_tmp_q);

	assign samp_evt  = !shut && (samp_inc > interval_q);
	assign samp_next = samp_evt ? samp_inc - interval_q : samp_inc;
	assign corr_next = samp_evt ?
		(TEMP_W'(raw_s2) + TEMP_W'(offset_q)) : corr_q;

	assign win_evt  = !shut && (win_inc > window_len_q);
	assign win_next = win_evt ? win_inc - window_len_q : win_inc;

	// Round demands up to whole mains periods, clamp to counter range
	assign brew_round_w  = {{PW{1'b0}}, brew_quot_s2} * {{QUOT_W{1'b0}}, PW'(PERIOD_MS)};
	assign steam_round_w = {{PW{1'b0}}, steam_quot_s2} * {{QUOT_W{1'b0}}, PW'(PERIOD_MS)};
	assign brew_round  = (brew_round_w > RW'(CNT_MAX)) ? CNT_MAX : brew_round_w[CNT_W-1:0];
	assign steam_round = (steam_round_w > RW'(CNT_MAX)) ? CNT_MAX : steam_round_w[CNT_W-1:0];

	// Bang-bang override uses the temperature latched on this very tick
	assign corr_ext   = DIFF_W'(corr_next);
	assign brew_diff  = $signed(DIFF_W'(brew_tgt_q)) - corr_ext;
	assign steam_diff = $signed(DIFF_W'(steam_tgt_q)) - corr_ext;

	assign brew_on_new = (brew_diff > OVER_BAND) ? window_len_q :
		(brew_diff < UNDER_BAND) ? '0 : brew_round;
	assign steam_on_new = (steam_diff > OVER_BAND) ? window_len_q :
		(steam_diff < UNDER_BAND) ? '0 : steam_round;

	assign brew_on_next  = win_evt ? brew_on_new : brew_on_q;
	assign steam_on_next = win_evt ? steam_on_new : steam_on_q;

	assign heater_next = !shut && (brew_on_next > win_next);
	assign steam_next  = !shut && (steam_on_next > win_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_el_q   <= '0;
			samp_el_q  <= '0;
			corr_q     <= '0;
			brew_on_q  <= '0;
			steam_on_q <= '0;
		end else if (step) begin
			win_el_q   <= win_next;
			samp_el_q  <= samp_next;
			corr_q     <= corr_next;
			brew_on_q  <= brew_on_next;
			steam_on_q <= steam_on_next;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic                     heater_q;
	logic                     steam_q;
	logic                     shut_q;
	logic                     strobe_q;
	logic signed [TEMP_W-1:0] held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			heater_q <= heater_next;
			steam_q  <= steam_next;
			shut_q   <= shut;
			strobe_q <= samp_evt;
			held_q   <= corr_next;
		end
	end

	assign drive.valid         = out_valid_q;
	assign drive.heater_on     = heater_q;
	assign drive.steam_on      = steam_q;
	assign drive.shutoff       = shut_q;
	assign drive.sample_strobe = strobe_q;
	assign drive.held_temp     = held_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`DTPHD_ASSERT_IMP(a_shut_relays_off, clk, arst_n, out_valid_q && shut_q,
		!heater_q && !steam_q && !strobe_q, "relay or strobe active during shutoff")

	`DTPHD_ASSERT_NXT(a_temp_only_on_strobe, clk, arst_n, step && !samp_evt,
		$stable(corr_q), "held temperature changed without a sample")

	`DTPHD_ASSERT_NXT(a_on_time_only_on_window, clk, arst_n, step && !win_evt,
		$stable(brew_on_q) && $stable(steam_on_q), "on-time changed off a window edge")

	`DTPHD_ASSERT_NXT(a_s2_held_on_stall, clk, arst_n, v_s2 && !out_free,
		v_s2 && $stable(raw_s2) && $stable(win_el_q), "stage 2 lost a stalled tick")

endmodule

// File: verif/dual_time_proportional_heater_drive_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the dual heater relay drive: directed ticks, then random phases.
module dual_time_proportional_heater_drive_top_tb;
	import dtphd_pkg::*;

	localparam int MAINS_HZ = MAINS_FREQUENCY_HZ_DEF;
	// Mains period in ms; a nonsense frequency falls back to a 1 ms period
	localparam int MAINS_PERIOD_MS = (1000 / MAINS_HZ == 0) ? 1 : 1000 / MAINS_HZ;
	localparam int RAW_MAX = 2 ** (RAW_W - 1) - 1;
	localparam int CYCLE_LIMIT = 1000000;
	// Three register stages between a tick and its drive result, plus margin
	localparam int SETTLE_CYCLES = 4;
	localparam int MISMATCH_SHOWN = 10;
	localparam int PHASES = 10;
	localparam int PHASE_TICKS = 55;
	localparam int DIR_ROWS = 32;
	// Index outside the register map; the block must drop the write
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

	typedef struct packed {
		logic heater;
		logic steam;
		logic shut;
		logic strobe;
		logic signed [TEMP_W-1:0] held;
	} drive_res_t;

	typedef struct {
		bit on;
		drive_res_t want;
	} pinned_t;

	typedef enum {ROW_TICK, ROW_CFG} row_kind_t;

	// One line of the directed sequence: either a register write or a tick.
	// A tick row may pin its result when it is obvious by inspection.
	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		int data;
		int raw;
		int brew;
		int steam;
		bit pinned;
		drive_res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dtphd_cfg_if cfg_bus();
	dtphd_tick_if tick_bus();
	dtphd_drive_if drive_bus();

	dual_time_proportional_heater_drive_top #(
		.MAINS_FREQUENCY_HZ(MAINS_HZ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.tick(tick_bus),
		.drive(drive_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Mirror of the block: register copies and the five pieces of state.
	// ------------------------------------------------------------------
	logic [BREW_TGT_W-1:0] brew_sp = BREW_TARGET_RST;
	logic [STEAM_TGT_W-1:0] steam_sp = STEAM_TARGET_RST;
	logic signed [OFFSET_W-1:0] offs = PROBE_OFFSET_RST;
	logic [CNT_W-1:0] win_len = WINDOW_LENGTH_RST;
	logic [CNT_W-1:0] smp_int = SAMPLE_INTERVAL_RST;
	logic [CNT_W-1:0] trip = SHUTOFF_TEMP_RST;

	logic [CNT_W-1:0] win_ms = '0;
	logic [CNT_W-1:0] smp_ms = '0;
	logic [CNT_W-1:0] brew_on_ms = '0;
	logic [CNT_W-1:0] steam_on_ms = '0;
	logic signed [TEMP_W-1:0] held_t = '0;

	// Expected drive results, oldest first, and the pins that ride with each tick
	drive_res_t drive_exp_q[$];
	pinned_t pinned_q[$];

	int ticks_sent = 0;
	int drives_seen = 0;
	int mismatch_cnt = 0;
	int stall_left = 0;
	int shut_burst = 0;
	bit no_idle = 1'b0;

	drive_res_t tick_pred;
	drive_res_t got_drive;
	pinned_t tick_pin;

	dir_row_t dir_tab [DIR_ROWS];

	// Round a demand up to whole mains periods, saturating at the counter ceiling.
	function automatic logic [CNT_W-1:0] mains_round(int dm);
		int r;
		r = dm % MAINS_PERIOD_MS;
		if (r != 0)
			dm = dm + MAINS_PERIOD_MS - r;
		return (dm > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(dm);
	endfunction

	// Bang-bang band first: far below the set point means full window,
	// slightly above it means off; in between the rounded demand holds.
	function automatic logic [CNT_W-1:0] relay_on_ms(int dm, int sp);
		int d;
		d = sp - int'(held_t);
		if (d > int'(OVER_BAND))
			return win_len;
		if (d < int'(UNDER_BAND))
			return '0;
		return mains_round(dm);
	endfunction

	// Advance the mirror by one millisecond tick and return its drive result.
	function automatic drive_res_t advance_tick(int raw, int brew_dm, int steam_dm);
		drive_res_t r;
		r = '0;
		if (win_ms != CNT_MAX)
			win_ms = win_ms + 1'b1;
		if (smp_ms != CNT_MAX)
			smp_ms = smp_ms + 1'b1;
		if (raw < 0 || raw >= int'(trip)) begin
			// Trip: relays off, nothing latched, counters keep running
			r.shut = 1'b1;
		end else begin
			if (smp_ms > smp_int) begin
				held_t = TEMP_W'(raw + int'(offs));
				smp_ms = smp_ms - smp_int;
				r.strobe = 1'b1;
			end
			// Window latch sees the temperature sampled on this same tick
			if (win_ms > win_len) begin
				win_ms = win_ms - win_len;
				brew_on_ms = relay_on_ms(brew_dm, int'(brew_sp));
				steam_on_ms = relay_on_ms(steam_dm, int'(steam_sp));
			end
			r.heater = brew_on_ms > win_ms;
			r.steam = steam_on_ms > win_ms;
		end
		r.held = held_t;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BREW_TARGET: brew_sp = data[BREW_TGT_W-1:0];
			REG_STEAM_TARGET: steam_sp = data[STEAM_TGT_W-1:0];
			REG_PROBE_OFFSET: offs = data[OFFSET_W-1:0];
			REG_WINDOW_LENGTH: win_len = data;
			REG_SAMPLE_INTERVAL: smp_int = data;
			REG_SHUTOFF_TEMP: trip = data;
			default: ;
		endcase
	endfunction

	function automatic void check_drive(drive_res_t got, drive_res_t want);
		if (got.heater !== want.heater || got.steam !== want.steam ||
				got.shut !== want.shut || got.strobe !== want.strobe ||
				got.held !== want.held) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MISMATCH_SHOWN)
				$display("drive mismatch %0d: want heater=%0b steam=%0b shutoff=%0b ",
					mismatch_cnt, want.heater, want.steam, want.shut,
					"strobe=%0b held=%0d | got heater=%0b steam=%0b shutoff=%0b ",
					want.strobe, want.held, got.heater, got.steam, got.shut,
					"strobe=%0b held=%0d", got.strobe, got.held);
		end
	endfunction

	// Mostly short waits, now and then a long one
	function automatic int pick_wait();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(2, 1);
		if (r < 92)
			return $urandom_range(6, 3);
		return $urandom_range(40, 10);
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample every handshake on the rising edge, before any of
	// this edge's updates land, so the order of processes does not matter.
	// Register writes and ticks update the mirror here, in bus order.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				apply_reg(cfg_bus.idx, cfg_bus.data);
			if (tick_bus.valid && tick_bus.ready) begin
				tick_pred = advance_tick(int'(tick_bus.raw_temp),
					int'(tick_bus.brew_demand), int'(tick_bus.steam_demand));
				tick_pin = pinned_q.pop_front();
				// A pinned row is held to its typed value; the mirror still advances
				drive_exp_q.push_back(tick_pin.on ? tick_pin.want : tick_pred);
			end
			if (drive_bus.valid && drive_bus.ready) begin
				drives_seen++;
				got_drive = '{drive_bus.heater_on, drive_bus.steam_on, drive_bus.shutoff,
					drive_bus.sample_strobe, drive_bus.held_temp};
				if (drive_exp_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MISMATCH_SHOWN)
						$display("drive result with no tick pending: held=%0d",
							got_drive.held);
				end else begin
					check_drive(got_drive, drive_exp_q.pop_front());
				end
			end
			// Receiver back-pressure: hold ready low for random stretches
			if (stall_left > 0) begin
				stall_left--;
				drive_bus.ready <= 1'b0;
			end else begin
				drive_bus.ready <= 1'b1;
				if (!no_idle && $urandom_range(99) < 20)
					stall_left = pick_wait();
			end
		end
	end

	function automatic int pick_gap();
		if (no_idle || $urandom_range(1) == 0)
			return 0;
		return pick_wait();
	endfunction

	// A reading that trips the drive: negative, or at or above the limit
	function automatic int shutoff_raw();
		if ($urandom_range(1) == 0)
			return -int'($urandom_range(4096, 1));
		return int'($urandom_range(RAW_MAX, int'(trip)));
	endfunction

	// Mostly readings close to one set point, so the bang-bang band and the
	// rounded demand both come into play; the rest are trips and noise.
	function automatic int gen_raw();
		int r;
		int sp;
		int raw;
		if (shut_burst > 0) begin
			shut_burst--;
			return shutoff_raw();
		end
		if ($urandom_range(99) < 2)
			shut_burst = $urandom_range(150, 10);
		r = $urandom_range(99);
		if (r < 60) begin
			sp = ($urandom_range(1) == 0) ? int'(brew_sp) : int'(steam_sp);
			raw = sp - int'(offs) + int'($urandom_range(240)) - 140;
			return (raw > RAW_MAX) ? RAW_MAX : raw;
		end
		if (r < 75)
			return int'($urandom_range(trip == 0 ? 0 : int'(trip) - 1));
		if (r < 85)
			return shutoff_raw();
		return int'($signed(RAW_W'($urandom)));
	endfunction

	function automatic int gen_demand();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(4000);
		if (r < 75)
			return $urandom_range(250) * MAINS_PERIOD_MS;
		if (r < 85)
			return ($urandom_range(1) == 0) ? 4095 : int'($urandom_range(1));
		return int'(DEMAND_W'($urandom));
	endfunction

	// Offer one tick request after a random gap and hold it until taken.
	task automatic send_tick(input int raw, input int brew_dm, input int steam_dm,
			input bit pin, input drive_res_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pinned_q.push_back('{pin, want});
		tick_bus.valid <= 1'b1;
		tick_bus.raw_temp <= RAW_W'(raw);
		tick_bus.brew_demand <= DEMAND_W'(brew_dm);
		tick_bus.steam_demand <= DEMAND_W'(steam_dm);
		do @(posedge clk); while (!tick_bus.ready);
		ticks_sent++;
	endtask

	// Write a register with the block idle: drop tick valid, drain all
	// results, let the pipe settle, then hold the write until taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		tick_bus.valid <= 1'b0;
		while (drives_seen < ticks_sent) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.idx <= idx;
		cfg_bus.data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	// Settings for one random phase. A few phases pin the extremes.
	task automatic program_regs(input int ph);
		int bt;
		int st;
		int po;
		int wl;
		int si;
		int sd;
		int r;
		// Bit 11 of the brew target is not stored; set it now and then
		bt = $urandom_range(1680, 1360) | (($urandom_range(3) == 0) ? 2048 : 0);
		st = $urandom_range(2400, 2080);
		if ($urandom_range(9) == 0)
			po = int'($urandom_range(511)) - 256;
		else
			po = int'($urandom_range(352)) - 176;
		r = $urandom_range(9);
		wl = (r < 7) ? $urandom_range(120, 16) :
			(r < 9) ? $urandom_range(4000, 16) : (($urandom_range(1) == 0) ? 0 : 4095);
		r = $urandom_range(9);
		si = (r < 7) ? $urandom_range(40, 1) :
			(r < 9) ? $urandom_range(4000, 1) : (($urandom_range(1) == 0) ? 0 : 4095);
		r = $urandom_range(9);
		sd = (r < 8) ? $urandom_range(2800, 2300) :
			(r == 8) ? $urandom_range(4095) : 4095;
		case (ph)
			0: begin
				bt = BREW_TARGET_RST;
				st = STEAM_TARGET_RST;
				po = PROBE_OFFSET_RST;
				wl = WINDOW_LENGTH_RST;
				si = SAMPLE_INTERVAL_RST;
				sd = SHUTOFF_TEMP_RST;
			end
			1: begin
				bt = 1360;
				st = 2080;
				po = -176;
				wl = 16;
				si = 1;
			end
			2: begin
				bt = 1680;
				st = 2400;
				po = 176;
				wl = 4000;
				si = 4000;
				sd = 4095;
			end
			3: begin
				// Zero window and interval: both events fire on every tick that does not trip
				wl = 0;
				si = 0;
			end
			default: ;
		endcase
		write_reg(REG_BREW_TARGET, bt);
		write_reg(REG_STEAM_TARGET, st);
		write_reg(REG_PROBE_OFFSET, po);
		write_reg(REG_WINDOW_LENGTH, wl);
		write_reg(REG_SAMPLE_INTERVAL, si);
		write_reg(REG_SHUTOFF_TEMP, sd);
	endtask

	// Hard stop in case the block hangs
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int ph;
		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.raw_temp = '0;
		tick_bus.brew_demand = '0;
		tick_bus.steam_demand = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.idx = '0;
		cfg_bus.data = '0;
		drive_bus.ready = 1'b0;

		// Directed part at reset settings first: a plain tick with nothing
		// latched, then trips at both ends of the reading and at the limit.
		// Next a dropped write, a zero interval (sample on every tick), a
		// minimum window, and a run of demands around the mains period up to
		// the rounding overflow. Last, a zero limit (everything trips) and
		// intervals of 4095 that never fire.
		dir_tab = '{
			'{ROW_TICK, '0, 0, 1000, 0, 0, 1'b1, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, -1, 4095, 4095, 1'b1, '{0, 0, 1, 0, 0}},
			'{ROW_TICK, '0, 0, -4096, 0, 0, 1'b1, '{0, 0, 1, 0, 0}},
			'{ROW_TICK, '0, 0, 2640, 1, 1, 1'b1, '{0, 0, 1, 0, 0}},
			'{ROW_TICK, '0, 0, 4095, 2048, 2048, 1'b1, '{0, 0, 1, 0, 0}},
			'{ROW_TICK, '0, 0, 2639, 4000, 4000, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_UNUSED, 4095, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_SAMPLE_INTERVAL, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_WINDOW_LENGTH, 16, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1600, 0, 0, 1'b1, '{0, 0, 0, 1, 1472}},
			'{ROW_CFG, REG_BREW_TARGET, 1360, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_STEAM_TARGET, 2400, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_PROBE_OFFSET, 176, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1184, 0, 4095, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1184, 1, 4000, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1200, 15, 17, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1250, 16, 33, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1150, 17, 4095, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1100, 4000, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1190, 4095, 1, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1170, 2047, 2048, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1175, 4095, 4095, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1180, 4095, 3, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1160, 31, 4095, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_PROBE_OFFSET, -176, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_SHUTOFF_TEMP, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 0, 100, 100, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_SHUTOFF_TEMP, 4095, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_WINDOW_LENGTH, 4095, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_CFG, REG_SAMPLE_INTERVAL, 4095, 0, 0, 0, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 4094, 500, 500, 1'b0, '{0, 0, 0, 0, 0}},
			'{ROW_TICK, '0, 0, 1536, 2000, 2000, 1'b0, '{0, 0, 0, 0, 0}}
		};

		// Hold reset, then release it on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				send_tick(dir_tab[i].raw, dir_tab[i].brew, dir_tab[i].steam,
					dir_tab[i].pinned, dir_tab[i].want);
		end

		// Random phases, each under fresh settings. Every fourth phase runs
		// with no gaps and no stalls.
		for (ph = 0; ph < PHASES; ph++) begin
			program_regs(ph);
			no_idle = (ph % 4 == 3);
			repeat (PHASE_TICKS) send_tick(gen_raw(), gen_demand(), gen_demand(), 1'b0, '0);
		end
		no_idle = 1'b0;

		// Drop valid, drain every result, then give the pipe time to show
		// anything extra before the verdict
		tick_bus.valid <= 1'b0;
		while (drives_seen < ticks_sent) @(posedge clk);
		repeat (SETTLE_CYCLES + 4) @(posedge clk);
		if (drive_exp_q.size() != 0) begin
			mismatch_cnt++;
			$display("%0d drive results never arrived", drive_exp_q.size());
		end

		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
